/* hw/rtl/abvg_pkg.sv */
// shared types, constants and band tables for the abv from gravity readings core
package abvg_pkg;

	localparam int GRAV_W    = 14;
	localparam int ABV_W     = 23;
	localparam int BAND_W    = 4;
	localparam int DIFF_W    = GRAV_W + 1;
	localparam int DEN_W     = 15;
	localparam int MF_W      = 2 * GRAV_W;
	localparam int K_W       = 23;
	localparam int KMF_W     = K_W + MF_W;
	localparam int QUO_W     = 26;
	localparam int NUM_W     = 35;
	localparam int TAB_W     = 18;
	localparam int TDIFF_W   = 10;
	localparam int FACT_W    = 8;
	localparam int BAND_COUNT = 11;

	localparam logic [BAND_W-1:0] NO_BAND       = 4'd11;
	localparam logic [K_W-1:0]    FALLBACK_K_Q16 = 23'd6279570;
	localparam logic [DEN_W-1:0]  GRAVITY_POLE   = 15'd17750;
	localparam logic [QUO_W-1:0]  ABV_LIMIT      = 26'd4000000;

	// per item data that rides alongside the arithmetic
	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic              err;
		logic              neg;
		logic              oor;
		logic [TAB_W-1:0]  tab;
	} sb_t;

	// state held by one divider cell
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] dq;
		logic [DEN_W-1:0] den;
		sb_t              sb;
	} cell_t;

	function automatic logic [DIFF_W-1:0] band_lo(input int idx);
		case (idx)
			0:       band_lo = 15'd0;
			1:       band_lo = 15'd70;
			2:       band_lo = 15'd105;
			3:       band_lo = 15'd173;
			4:       band_lo = 15'd262;
			5:       band_lo = 15'd361;
			6:       band_lo = 15'd466;
			7:       band_lo = 15'd572;
			8:       band_lo = 15'd680;
			9:       band_lo = 15'd789;
			default: band_lo = 15'd898;
		endcase
	endfunction

	function automatic logic [DIFF_W-1:0] band_hi(input int idx);
		case (idx)
			0:       band_hi = 15'd69;
			1:       band_hi = 15'd104;
			2:       band_hi = 15'd172;
			3:       band_hi = 15'd261;
			4:       band_hi = 15'd360;
			5:       band_hi = 15'd465;
			6:       band_hi = 15'd571;
			7:       band_hi = 15'd679;
			8:       band_hi = 15'd788;
			9:       band_hi = 15'd897;
			default: band_hi = 15'd1007;
		endcase
	endfunction

	function automatic logic [FACT_W-1:0] band_factor(input logic [BAND_W-1:0] b);
		case (b)
			4'd0:    band_factor = 8'd125;
			4'd1:    band_factor = 8'd126;
			4'd2:    band_factor = 8'd127;
			4'd3:    band_factor = 8'd128;
			4'd4:    band_factor = 8'd129;
			4'd5:    band_factor = 8'd130;
			4'd6:    band_factor = 8'd131;
			4'd7:    band_factor = 8'd132;
			4'd8:    band_factor = 8'd133;
			4'd9:    band_factor = 8'd134;
			4'd10:   band_factor = 8'd135;
			default: band_factor = 8'd0;
		endcase
	endfunction

	function automatic logic [TAB_W-1:0] band_min(input logic [BAND_W-1:0] b);
		case (b)
			4'd0:    band_min = 18'd0;
			4'd1:    band_min = 18'd8000;
			4'd2:    band_min = 18'd13000;
			4'd3:    band_min = 18'd22000;
			4'd4:    band_min = 18'd33000;
			4'd5:    band_min = 18'd46000;
			4'd6:    band_min = 18'd60000;
			4'd7:    band_min = 18'd75000;
			4'd8:    band_min = 18'd90000;
			4'd9:    band_min = 18'd105000;
			4'd10:   band_min = 18'd120000;
			default: band_min = 18'd0;
		endcase
	endfunction

	function automatic logic [TAB_W-1:0] band_max(input logic [BAND_W-1:0] b);
		case (b)
			4'd0:    band_max = 18'd8000;
			4'd1:    band_max = 18'd13000;
			4'd2:    band_max = 18'd21000;
			4'd3:    band_max = 18'd33000;
			4'd4:    band_max = 18'd46000;
			4'd5:    band_max = 18'd60000;
			4'd6:    band_max = 18'd75000;
			4'd7:    band_max = 18'd90000;
			4'd8:    band_max = 18'd105000;
			4'd9:    band_max = 18'd120000;
			4'd10:   band_max = 18'd136000;
			default: band_max = 18'd0;
		endcase
	endfunction

	// band search on a signed difference, first matching band wins
	function automatic logic [BAND_W-1:0] band_of(input logic signed [DIFF_W-1:0] d);
		logic [BAND_W-1:0] b;
		b = NO_BAND;
		for (int i = BAND_COUNT - 1; i >= 0; i--) begin
			if (!d[DIFF_W-1] && (d >= $signed(band_lo(i))) && (d <= $signed(band_hi(i))))
				b = BAND_W'(i);
		end
		return b;
	endfunction

endpackage

/* hw/rtl/abvg_div_cell.sv */
// one restoring division cell: produces one quotient bit and hands on to its neighbor
module abvg_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  abvg_pkg::cell_t in_cell,
	output logic           out_valid,
	output abvg_pkg::cell_t out_cell
);
	import abvg_pkg::*;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;
	cell_t            nxt;

	// shift in the next dividend bit and try to subtract the divisor
	always_comb begin
		trial = {in_cell.rem, in_cell.dq[QUO_W-1]};
		ge    = trial >= {1'b0, in_cell.den};
		diff  = trial - {1'b0, in_cell.den};
		nxt   = in_cell;
		nxt.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		nxt.dq  = {in_cell.dq[QUO_W-2:0], ge};
	end

	// valid travels with the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			out_cell <= nxt;
		end
	end

endmodule

/* hw/rtl/abv_from_gravity_readings_core.sv */
// top level of the abv from gravity readings core
//
// Input channel: og_sg and fg_sg, accepted when in_valid is high and in_stall low.
// Output channel: abv_e4 with used_fallback, band_index, out_of_expected_range and
// gravity_order_error, taken when out_valid is high and out_stall low.
// Every transaction gives exactly one result, in order.
// Pipeline: four front stages (band search and difference, products, Q16 scaling,
// rounding offset), a chain of 26 divider cells that each make one quotient bit,
// and the output register. Throughput: one transaction per cycle unless stalled;
// the divider chain is fully pipelined.
// Stall: each stage moves on when the stage after it is empty or moving, so a
// stalled output holds its result while bubbles further up still close up and
// new transactions are still accepted until the pipeline is full.
// Reset: arst_n clears all valid flags at once; the block is ready right after.
module abv_from_gravity_readings_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [abvg_pkg::GRAV_W-1:0] og_sg,
	input  logic [abvg_pkg::GRAV_W-1:0] fg_sg,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [abvg_pkg::ABV_W-1:0] abv_e4,
	output logic                        used_fallback,
	output logic [abvg_pkg::BAND_W-1:0] band_index,
	output logic                        out_of_expected_range,
	output logic                        gravity_order_error
);
	import abvg_pkg::*;

	// front stage registers
	logic                 v_s1, v_s2, v_s3, v_s4;
	sb_t                  sb_s1, sb_s2, sb_s3, sb_s4;
	logic [GRAV_W-1:0]    mag_s1, fg_s1;
	logic [DEN_W-1:0]     den_s1, den_s2, den_s3;
	logic [TDIFF_W-1:0]   tdiff_s1;
	logic [MF_W-1:0]      mf_s2;
	logic [KMF_W-1:0]     kmf_s3;
	cell_t                cell_s4;

	logic                 rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	logic                 cv   [QUO_W];
	cell_t                cc   [QUO_W];
	logic                 rdy_c [QUO_W];

	logic signed [DIFF_W-1:0] diff;
	logic [KMF_W:0]       num_sum;
	logic [NUM_W-1:0]     num;
	logic [QUO_W-1:0]     q_sat;
	logic [ABV_W-1:0]     q_abv;
	logic [ABV_W-1:0]     fb_abv;

	// ready chain, from the output back to the input
	assign rdy_out = !out_valid || !out_stall;
	always_comb begin
		rdy_c[QUO_W-1] = !cv[QUO_W-1] || rdy_out;
		for (int i = QUO_W - 2; i >= 0; i--) begin
			rdy_c[i] = !cv[i] || rdy_c[i+1];
		end
	end
	assign rdy_s4   = !v_s4 || rdy_c[0];
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// front valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: difference, band search, magnitude and divisor
	assign diff = $signed({1'b0, og_sg}) - $signed({1'b0, fg_sg});
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sb_s1.band <= band_of(diff);
			sb_s1.err  <= fg_sg > og_sg;
			sb_s1.neg  <= diff[DIFF_W-1];
			sb_s1.oor  <= 1'b0;
			sb_s1.tab  <= '0;
			mag_s1     <= diff[DIFF_W-1] ? (fg_sg - og_sg) : (og_sg - fg_sg);
			fg_s1      <= fg_sg;
			den_s1     <= GRAVITY_POLE - {1'b0, og_sg};
			tdiff_s1   <= diff[TDIFF_W-1:0];
		end
	end

	// stage 2: table product and gravity product
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			sb_s2.band <= sb_s1.band;
			sb_s2.err  <= sb_s1.err;
			sb_s2.neg  <= sb_s1.neg;
			sb_s2.oor  <= sb_s1.oor;
			sb_s2.tab  <= {(TAB_W - TDIFF_W)'(0), tdiff_s1} *
				{(TAB_W - FACT_W)'(0), band_factor(sb_s1.band)};
			mf_s2      <= mag_s1 * fg_s1;
			den_s2     <= den_s1;
		end
	end

	// stage 3: expected range check and Q16 scaling
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sb_s3.band <= sb_s2.band;
			sb_s3.err  <= sb_s2.err;
			sb_s3.neg  <= sb_s2.neg;
			sb_s3.tab  <= sb_s2.tab;
			sb_s3.oor  <= (sb_s2.band != NO_BAND) &&
				((sb_s2.tab < band_min(sb_s2.band)) || (sb_s2.tab > band_max(sb_s2.band)));
			kmf_s3     <= FALLBACK_K_Q16 * mf_s2;
			den_s3     <= den_s2;
		end
	end

	// stage 4: add half the divisor, drop the Q16 fraction, load the divider
	assign num_sum = {1'b0, kmf_s3} + {(KMF_W + 1 - DEN_W - 15)'(0), den_s3, 15'd0};
	assign num     = num_sum[NUM_W+15:16];
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			cell_s4.rem <= {(DEN_W - (NUM_W - QUO_W))'(0), num[NUM_W-1:QUO_W]};
			cell_s4.dq  <= num[QUO_W-1:0];
			cell_s4.den <= den_s3;
			cell_s4.sb  <= sb_s3;
		end
	end

	// divider chain
	for (genvar g = 0; g < QUO_W; g++) begin : g_cell
		if (g == 0) begin : g_first
			abvg_div_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (rdy_c[g]),
				.in_valid  (v_s4),
				.in_cell   (cell_s4),
				.out_valid (cv[g]),
				.out_cell  (cc[g])
			);
		end else begin : g_rest
			abvg_div_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (rdy_c[g]),
				.in_valid  (cv[g-1]),
				.in_cell   (cc[g-1]),
				.out_valid (cv[g]),
				.out_cell  (cc[g])
			);
		end
	end

	// saturate and sign the fallback quotient
	assign q_sat  = (cc[QUO_W-1].dq > ABV_LIMIT) ? ABV_LIMIT : cc[QUO_W-1].dq;
	assign q_abv  = q_sat[ABV_W-1:0];
	assign fb_abv = cc[QUO_W-1].sb.neg ? (~q_abv + 1'b1) : q_abv;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_out) begin
			out_valid <= cv[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			if (cc[QUO_W-1].sb.band == NO_BAND) begin
				abv_e4        <= $signed(fb_abv);
				used_fallback <= 1'b1;
			end else begin
				abv_e4        <= $signed({(ABV_W - TAB_W)'(0), cc[QUO_W-1].sb.tab});
				used_fallback <= 1'b0;
			end
			band_index            <= cc[QUO_W-1].sb.band;
			out_of_expected_range <= cc[QUO_W-1].sb.oor;
			gravity_order_error   <= cc[QUO_W-1].sb.err;
		end
	end

endmodule
